[sv/assert_macros.svh]
// Assertion macros used by the back end of the binary to decimal ASCII unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/b2da_pkg.sv]
// Types and constants of the binary to decimal ASCII unit.
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

	localparam int MAX_DIGITS = 8;
	localparam int VALUE_W    = 16;
	localparam int MIN_W      = 4;
	localparam int LEN_W      = 4;
	localparam int CHAR_W     = 6;
	localparam int NUM_BCD    = 5;
	localparam int BCD_IDX_W  = $clog2(NUM_BCD);
	localparam int SIG_W      = $clog2(NUM_BCD + 1);
	localparam int STEP_W     = $clog2(VALUE_W);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [MIN_W-1:0]   min_digits;
	} in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic [LEN_W-1:0]  length;
		logic              is_last;
		logic              is_empty;
	} res_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [LEN_W-1:0]   minc;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_SIZE,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

[sv/binary_to_decimal_ascii_unit.sv]
// After a transaction is accepted the back end runs the 16 double-dabble shift steps,
// sizes the string and then emits it at one character per cycle while the result
// queue is not full; it takes the next value only after its last character is out.
// Up to two values wait in the front queue and two characters in the result queue.
// Reset (arst_n low) empties both queues and returns the converter to idle at once.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_unit
	import b2da_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire in_t  item,
	output logic      empty,
	input  wire logic pop,
	output res_t      result
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_push;
	logic res_full;
	res_t res;

	b2da_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	b2da_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_push  (res_push),
		.res_full  (res_full),
		.res       (res)
	);

	b2da_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_full (res_full),
		.res_in   (res),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

[sv/b2da_front.sv]
// Front end: accepts transactions, saturates the minimum count and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module b2da_front
	import b2da_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire in_t  item,
	output logic      cmd_valid,
	input  wire logic cmd_ready,
	output cmd_t      cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;
	cmd_t       new_cmd;

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rd_ptr_q];

	always_comb begin
		new_cmd.value = item.value;
		if (item.min_digits > LEN_W'(MAX_DIGITS)) begin
			new_cmd.minc = LEN_W'(MAX_DIGITS);
		end else begin
			new_cmd.minc = LEN_W'(item.min_digits);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/b2da_back.sv]
// Back end: double-dabble conversion and serial character emission.
`timescale 1ns / 1ps
`default_nettype none

module b2da_back
	import b2da_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      res_push,
	input  wire logic res_full,
	output res_t      res
);

`include "assert_macros.svh"

	back_state_t                 state_q;
	back_state_t                 state_d;
	cmd_t                        cmd_q;
	logic [VALUE_W-1:0]          shreg_q;
	logic [NUM_BCD-1:0][3:0]     bcd_q;
	logic [NUM_BCD-1:0][3:0]     bcd_adj;
	logic [4*NUM_BCD-1:0]        bcd_flat;
	logic [STEP_W-1:0]           step_q;
	logic [LEN_W-1:0]            len_q;
	logic [LEN_W-1:0]            idx_q;
	logic [SIG_W-1:0]            sig;
	logic [LEN_W-1:0]            len_d;
	logic [LEN_W-1:0]            pos;
	logic [3:0]                  digit;
	logic                        take;
	logic                        last_char;

	always_comb begin
		for (int k = 0; k < NUM_BCD; k++) begin
			bcd_adj[k] = (bcd_q[k] >= 4'd5) ? (bcd_q[k] + 4'd3) : bcd_q[k];
		end
	end

	assign bcd_flat = bcd_adj;

	always_comb begin
		sig = '0;
		for (int k = 0; k < NUM_BCD; k++) begin
			if (bcd_q[k] != 4'd0) begin
				sig = SIG_W'(k + 1);
			end
		end
		len_d = (LEN_W'(sig) > cmd_q.minc) ? LEN_W'(sig) : cmd_q.minc;
	end

	always_comb begin
		pos = len_q - LEN_W'(1) - idx_q;
		if (pos < LEN_W'(NUM_BCD)) begin
			digit = bcd_q[pos[BCD_IDX_W-1:0]];
		end else begin
			digit = 4'd0;
		end
		last_char = (len_q == LEN_W'(0)) || (idx_q == len_q - LEN_W'(1));
	end

	assign take = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		unique case (state_q)
			B_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = B_CONV;
				end
			end
			B_CONV: begin
				if (step_q == STEP_W'(VALUE_W - 1)) begin
					state_d = B_SIZE;
				end
			end
			B_SIZE: begin
				state_d = B_EMIT;
			end
			B_EMIT: begin
				res.length  = len_q;
				res.is_last = last_char;
				if (len_q == LEN_W'(0)) begin
					res.is_empty = 1'b1;
				end else begin
					res.digit_char = ASCII_ZERO + CHAR_W'(digit);
				end
				if (!res_full) begin
					res_push = 1'b1;
					if (last_char) begin
						state_d = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q   <= cmd;
			shreg_q <= cmd.value;
			bcd_q   <= '0;
		end else if (state_q == B_CONV) begin
			shreg_q <= {shreg_q[VALUE_W-2:0], 1'b0};
			bcd_q   <= {bcd_flat[4*NUM_BCD-2:0], shreg_q[VALUE_W-1]};
		end
		if (state_q == B_SIZE) begin
			len_q <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			idx_q  <= '0;
		end else begin
			if (take) begin
				step_q <= '0;
			end else if (state_q == B_CONV) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (state_q == B_SIZE) begin
				idx_q <= '0;
			end else if (res_push) begin
				idx_q <= idx_q + LEN_W'(1);
			end
		end
	end

	`ASSERT_SAME(a_char_is_digit,
		res_push && !res.is_empty,
		res.digit_char >= ASCII_ZERO && res.digit_char <= ASCII_NINE,
		"emitted character is not a decimal digit")
	`ASSERT_SAME(a_len_bounds,
		state_q == B_EMIT,
		len_q >= cmd_q.minc && len_q <= LEN_W'(MAX_DIGITS),
		"string length outside its bounds")
	`ASSERT_NEXT(a_conv_to_size,
		state_q == B_CONV && step_q == STEP_W'(VALUE_W - 1),
		state_q == B_SIZE,
		"conversion did not finish after the last shift step")

endmodule

`default_nettype wire

[sv/b2da_outq.sv]
// Result queue between the back end and the result port.
`timescale 1ns / 1ps
`default_nettype none

module b2da_outq
	import b2da_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_push,
	output logic      res_full,
	input  wire res_t res_in,
	output logic      empty,
	input  wire logic pop,
	output res_t      result
);

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;
	assign result   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire
